@@ src/cau_pkg.sv @@
// Shared commands, status codes, flag groups and CORDIC constants of the complex arithmetic unit.
package cau_pkg;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_CONJ  = 4'd4,
        CMD_RECIP = 4'd5,
        CMD_SCALE = 4'd6,
        CMD_MAG   = 4'd7,
        CMD_ARG   = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        logic ovf;
        logic zero;
    } t_rcp_flags;

    typedef struct packed {
        logic mag_ovf;
        logic ang_ovf;
        logic nonzero;
    } t_cor_flags;

    // Angles are carried with 30 fraction bits.
    localparam int CAU_ANG_W = 34;
    localparam int CAU_ANG_FRAC = 30;

    localparam logic signed [CAU_ANG_W-1:0] CAU_PI = 34'sd3373259426;
    localparam logic signed [31:0] CAU_GAIN = 32'sd652032874;

    localparam logic signed [CAU_ANG_W-1:0] CAU_ATAN [32] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,
        34'sd63,        34'sd31,        34'sd15,        34'sd8,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

endpackage

@@ src/complex_arithmetic_unit.sv @@
// Top level of the pipelined fixed-point complex arithmetic unit.
// Each word feeds the reciprocal divider, one quotient bit per stage, and the CORDIC side by side;
// the shorter of the two paths is padded to the length of the longer.
// Throughput: one word per cycle; busy stays low and results cannot be held off.
// Reset clears only the valid bits; payload registers are not reset.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH   = 32,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [3:0]                  i_command,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                        o_done,
    output logic signed [DATA_WIDTH-1:0] o_result_re,
    output logic signed [DATA_WIDTH-1:0] o_result_im,
    output logic [1:0]                  o_status
);
    import cau_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int CS    = CORDIC_STEPS;
    localparam int PW    = 2 * DW;
    localparam int SW    = 2 * DW + 40;
    localparam int XW    = DW + 3;
    localparam int MW    = XW + 32;
    localparam int LD    = DW + 6;
    localparam int LC    = CS + 3;
    localparam int LF    = (LD > LC) ? LD : LC;
    localparam int PAD_R = LF - LD;
    localparam int PAD_C = LF - LC;
    localparam int CW    = 4 + 4 * DW;
    localparam int RPW   = 2 * DW + 2;
    localparam int CPW   = 2 * DW + 3;
    localparam int ZSH   = CAU_ANG_FRAC - FRAC_BITS;

    localparam logic signed [SW-1:0] S_MAX = (SW'(1) <<< (DW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] S_MIN = -(SW'(1) <<< (DW - 1));
    localparam logic signed [CAU_ANG_W:0] Z_HALF =
        (ZSH > 0) ? ((CAU_ANG_W+1)'(1) <<< ((ZSH > 0) ? ZSH - 1 : 0)) : '0;
    localparam logic signed [MW-1:0] G_HALF = MW'(1) <<< (CAU_ANG_FRAC - 1);
    localparam logic signed [PW+1:0] P_HALF = (PW+2)'(1) <<< (FRAC_BITS - 1);

    function automatic logic [DW:0] sat_w(input logic signed [SW-1:0] v);
        logic [DW:0] res;
        begin
            if (v > S_MAX)      res = {1'b1, S_MAX[DW-1:0]};
            else if (v < S_MIN) res = {1'b1, S_MIN[DW-1:0]};
            else                res = {1'b0, v[DW-1:0]};
            return res;
        end
    endfunction

    // Input stage.
    logic                 r_in_vld;
    t_cmd                 r_in_cmd;
    logic signed [DW-1:0] r_in_are, r_in_aim, r_in_bre, r_in_bim;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in_cmd <= t_cmd'(i_command);
        r_in_are <= i_a_re;
        r_in_aim <= i_a_im;
        r_in_bre <= i_b_re;
        r_in_bim <= i_b_im;
    end

    // Reciprocal of b for divide, of a otherwise.
    logic signed [DW-1:0] rq_re, rq_im;
    t_rcp_flags           rq_flags;

    cau_recip #(
        .DW (DW),
        .F  (FRAC_BITS)
    ) u_recip (
        .i_clk   (i_clk),
        .i_re    ((r_in_cmd == CMD_DIV) ? r_in_bre : r_in_are),
        .i_im    ((r_in_cmd == CMD_DIV) ? r_in_bim : r_in_aim),
        .o_q_re  (rq_re),
        .o_q_im  (rq_im),
        .o_flags (rq_flags)
    );

    // Vectoring CORDIC, one rotation per stage.
    logic signed [XW-1:0]        r_cx [0:CS];
    logic signed [XW-1:0]        r_cy [0:CS];
    logic signed [CAU_ANG_W-1:0] r_cz [0:CS];
    logic                        r_cnz [0:CS];
    logic signed [XW-1:0]        n_cx [0:CS-1];
    logic signed [XW-1:0]        n_cy [0:CS-1];
    logic signed [CAU_ANG_W-1:0] n_cz [0:CS-1];

    logic signed [MW-1:0]        r_g_prod;
    logic signed [CAU_ANG_W:0]   r_g_ang;
    logic                        r_g_nz;
    logic signed [DW-1:0]        r_cm_mag, r_cm_ang;
    t_cor_flags                  r_cm_flags;
    logic signed [MW-1:0]        n_mag_sh;
    logic signed [CAU_ANG_W:0]   n_ang_sh;
    logic [DW:0]                 n_mag_sat, n_ang_sat;

    always_comb begin
        for (int k = 0; k < CS; k++) begin
            if (!r_cy[k][XW-1] && (r_cy[k] != '0)) begin
                n_cx[k] = r_cx[k] + (r_cy[k] >>> k);
                n_cy[k] = r_cy[k] - (r_cx[k] >>> k);
                n_cz[k] = r_cz[k] + CAU_ATAN[5'(k)];
            end else begin
                n_cx[k] = r_cx[k] - (r_cy[k] >>> k);
                n_cy[k] = r_cy[k] + (r_cx[k] >>> k);
                n_cz[k] = r_cz[k] - CAU_ATAN[5'(k)];
            end
        end
    end

    assign n_mag_sh  = (r_g_prod + G_HALF) >>> CAU_ANG_FRAC;
    assign n_ang_sh  = r_g_ang >>> ZSH;
    assign n_mag_sat = sat_w(SW'(n_mag_sh));
    assign n_ang_sat = sat_w(SW'(n_ang_sh));

    always_ff @(posedge i_clk) begin
        if (r_in_are[DW-1]) begin
            r_cx[0] <= -XW'(r_in_are);
            r_cy[0] <= -XW'(r_in_aim);
            r_cz[0] <= r_in_aim[DW-1] ? -CAU_PI : CAU_PI;
        end else begin
            r_cx[0] <= XW'(r_in_are);
            r_cy[0] <= XW'(r_in_aim);
            r_cz[0] <= '0;
        end
        r_cnz[0] <= (r_in_are != '0) || (r_in_aim != '0);
        for (int k = 0; k < CS; k++) begin
            r_cx[k+1]  <= n_cx[k];
            r_cy[k+1]  <= n_cy[k];
            r_cz[k+1]  <= n_cz[k];
            r_cnz[k+1] <= r_cnz[k];
        end
        r_g_prod   <= MW'(r_cx[CS]) * MW'(CAU_GAIN);
        r_g_ang    <= (CAU_ANG_W+1)'(r_cz[CS]) + Z_HALF;
        r_g_nz     <= r_cnz[CS];
        r_cm_mag   <= n_mag_sat[DW-1:0];
        r_cm_ang   <= n_ang_sat[DW-1:0];
        r_cm_flags <= '{mag_ovf: n_mag_sat[DW], ang_ovf: n_ang_sat[DW], nonzero: r_g_nz};
    end

    // Alignment of the operands and of both units to the back stages.
    logic [CW-1:0]  r_cy_dat [1:LF];
    logic           r_cy_vld [1:LF];
    logic [RPW-1:0] rp_vec;
    logic [CPW-1:0] cp_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LF; k++) r_cy_vld[k] <= 1'b0;
        end else begin
            r_cy_vld[1] <= r_in_vld;
            for (int k = 2; k <= LF; k++) r_cy_vld[k] <= r_cy_vld[k-1];
        end
        r_cy_dat[1] <= {r_in_cmd, r_in_are, r_in_aim, r_in_bre, r_in_bim};
        for (int k = 2; k <= LF; k++) r_cy_dat[k] <= r_cy_dat[k-1];
    end

    if (PAD_R == 0) begin : g_rpad_none
        assign rp_vec = {rq_flags, rq_re, rq_im};
    end else begin : g_rpad
        logic [RPW-1:0] r_pad [0:PAD_R-1];
        always_ff @(posedge i_clk) begin
            r_pad[0] <= {rq_flags, rq_re, rq_im};
            for (int k = 1; k < PAD_R; k++) r_pad[k] <= r_pad[k-1];
        end
        assign rp_vec = r_pad[PAD_R-1];
    end

    if (PAD_C == 0) begin : g_cpad_none
        assign cp_vec = {r_cm_flags, r_cm_mag, r_cm_ang};
    end else begin : g_cpad
        logic [CPW-1:0] r_pad [0:PAD_C-1];
        always_ff @(posedge i_clk) begin
            r_pad[0] <= {r_cm_flags, r_cm_mag, r_cm_ang};
            for (int k = 1; k < PAD_C; k++) r_pad[k] <= r_pad[k-1];
        end
        assign cp_vec = r_pad[PAD_C-1];
    end

    t_cmd                 c_cmd;
    logic signed [DW-1:0] c_are, c_aim, c_bre, c_bim;
    logic signed [DW-1:0] rp_re, rp_im, cp_mag, cp_ang;
    t_rcp_flags           rp_flags;
    t_cor_flags           cp_flags;

    assign c_cmd    = t_cmd'(r_cy_dat[LF][CW-1 -: 4]);
    assign c_are    = r_cy_dat[LF][4*DW-1 -: DW];
    assign c_aim    = r_cy_dat[LF][3*DW-1 -: DW];
    assign c_bre    = r_cy_dat[LF][2*DW-1 -: DW];
    assign c_bim    = r_cy_dat[LF][DW-1:0];
    assign rp_flags = t_rcp_flags'(rp_vec[RPW-1 -: 2]);
    assign rp_re    = rp_vec[2*DW-1 -: DW];
    assign rp_im    = rp_vec[DW-1:0];
    assign cp_flags = t_cor_flags'(cp_vec[CPW-1 -: 3]);
    assign cp_mag   = cp_vec[2*DW-1 -: DW];
    assign cp_ang   = cp_vec[DW-1:0];

    // Back stage one: products and the results that need no product.
    logic                 r_b1_vld;
    t_cmd                 r_b1_cmd;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [DW-1:0] r_b1_s_re, r_b1_s_im;
    t_status              r_b1_s_st;
    logic                 r_b1_rovf, r_b1_zero;
    logic signed [DW-1:0] n_yr, n_yi, n_s_re, n_s_im;
    t_status              n_s_st;

    always_comb begin
        logic [DW:0] s_re;
        logic [DW:0] s_im;
        n_yr = (c_cmd == CMD_DIV) ? rp_re : c_bre;
        if (c_cmd == CMD_DIV)        n_yi = rp_im;
        else if (c_cmd == CMD_SCALE) n_yi = '0;
        else                         n_yi = c_bim;
        s_re = '0;
        s_im = '0;
        n_s_st = ST_OK;
        case (c_cmd)
            CMD_ADD: begin
                s_re = sat_w(SW'((DW+1)'(c_are) + (DW+1)'(c_bre)));
                s_im = sat_w(SW'((DW+1)'(c_aim) + (DW+1)'(c_bim)));
                n_s_st = (s_re[DW] | s_im[DW]) ? ST_OVF : ST_OK;
            end
            CMD_SUB: begin
                s_re = sat_w(SW'((DW+1)'(c_are) - (DW+1)'(c_bre)));
                s_im = sat_w(SW'((DW+1)'(c_aim) - (DW+1)'(c_bim)));
                n_s_st = (s_re[DW] | s_im[DW]) ? ST_OVF : ST_OK;
            end
            CMD_CONJ: begin
                s_re = {1'b0, c_are};
                s_im = sat_w(SW'((DW+1)'(0) - (DW+1)'(c_aim)));
                n_s_st = s_im[DW] ? ST_OVF : ST_OK;
            end
            CMD_RECIP: begin
                s_re = {1'b0, rp_re};
                s_im = {1'b0, rp_im};
                if (rp_flags.zero)    n_s_st = ST_DIV0;
                else if (rp_flags.ovf) n_s_st = ST_OVF;
                else                   n_s_st = ST_OK;
            end
            CMD_MAG: begin
                if (cp_flags.nonzero) begin
                    s_re = {1'b0, cp_mag};
                    n_s_st = cp_flags.mag_ovf ? ST_OVF : ST_OK;
                end
            end
            CMD_ARG: begin
                if (cp_flags.nonzero) begin
                    s_re = {1'b0, cp_ang};
                    n_s_st = cp_flags.ang_ovf ? ST_OVF : ST_OK;
                end
            end
            default: begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        n_s_re = s_re[DW-1:0];
        n_s_im = s_im[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
        end else begin
            r_b1_vld <= r_cy_vld[LF];
        end
        r_b1_cmd  <= c_cmd;
        r_p_rr    <= PW'(c_are) * PW'(n_yr);
        r_p_ii    <= PW'(c_aim) * PW'(n_yi);
        r_p_ri    <= PW'(c_are) * PW'(n_yi);
        r_p_ir    <= PW'(c_aim) * PW'(n_yr);
        r_b1_s_re <= n_s_re;
        r_b1_s_im <= n_s_im;
        r_b1_s_st <= n_s_st;
        r_b1_rovf <= rp_flags.ovf;
        r_b1_zero <= rp_flags.zero;
    end

    // Back stage two: product sums with the rounding half added.
    logic                   r_b2_vld;
    t_cmd                   r_b2_cmd;
    logic signed [PW+1:0]   r_sum_re, r_sum_im;
    logic signed [DW-1:0]   r_b2_s_re, r_b2_s_im;
    t_status                r_b2_s_st;
    logic                   r_b2_rovf, r_b2_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_vld <= 1'b0;
        end else begin
            r_b2_vld <= r_b1_vld;
        end
        r_b2_cmd  <= r_b1_cmd;
        r_sum_re  <= (PW+2)'(r_p_rr) - (PW+2)'(r_p_ii) + P_HALF;
        r_sum_im  <= (PW+2)'(r_p_ri) + (PW+2)'(r_p_ir) + P_HALF;
        r_b2_s_re <= r_b1_s_re;
        r_b2_s_im <= r_b1_s_im;
        r_b2_s_st <= r_b1_s_st;
        r_b2_rovf <= r_b1_rovf;
        r_b2_zero <= r_b1_zero;
    end

    // Back stage three: rounding shift, saturation and result selection.
    logic                 r_out_vld;
    logic signed [DW-1:0] r_out_re, r_out_im;
    t_status              r_out_st;
    logic signed [PW+1:0] n_sh_re, n_sh_im;
    logic [DW:0]          n_m_re, n_m_im;
    logic signed [DW-1:0] n_o_re, n_o_im;
    t_status              n_o_st;

    assign n_sh_re = r_sum_re >>> FRAC_BITS;
    assign n_sh_im = r_sum_im >>> FRAC_BITS;
    assign n_m_re  = sat_w(SW'(n_sh_re));
    assign n_m_im  = sat_w(SW'(n_sh_im));

    always_comb begin
        n_o_re = r_b2_s_re;
        n_o_im = r_b2_s_im;
        n_o_st = r_b2_s_st;
        case (r_b2_cmd)
            CMD_MUL, CMD_SCALE: begin
                n_o_re = n_m_re[DW-1:0];
                n_o_im = n_m_im[DW-1:0];
                n_o_st = (n_m_re[DW] | n_m_im[DW]) ? ST_OVF : ST_OK;
            end
            CMD_DIV: begin
                if (r_b2_zero) begin
                    n_o_re = '0;
                    n_o_im = '0;
                    n_o_st = ST_DIV0;
                end else begin
                    n_o_re = n_m_re[DW-1:0];
                    n_o_im = n_m_im[DW-1:0];
                    n_o_st = (r_b2_rovf | n_m_re[DW] | n_m_im[DW]) ? ST_OVF : ST_OK;
                end
            end
            default: begin
                n_o_re = r_b2_s_re;
                n_o_im = r_b2_s_im;
                n_o_st = r_b2_s_st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_b2_vld;
        end
        r_out_re <= n_o_re;
        r_out_im <= n_o_im;
        r_out_st <= n_o_st;
    end

    assign o_done      = r_out_vld;
    assign o_result_re = r_out_re;
    assign o_result_im = r_out_im;
    assign o_status    = r_out_st;

endmodule

@@ src/cau_recip.sv @@
// Pipelined complex reciprocal: squares, denominator, one quotient bit per stage, sign and saturation.
module cau_recip #(
    parameter int DW = 32,
    parameter int F  = 16
) (
    input  logic                    i_clk,
    input  logic signed [DW-1:0]    i_re,
    input  logic signed [DW-1:0]    i_im,
    output logic signed [DW-1:0]    o_q_re,
    output logic signed [DW-1:0]    o_q_im,
    output cau_pkg::t_rcp_flags     o_flags
);
    import cau_pkg::*;

    localparam int PW = 2 * DW;
    localparam int QB = DW + 1;
    localparam int NW = 2 * DW + 2 * F;
    localparam logic [QB-1:0] Q_LIM = QB'(1) << (DW - 1);
    localparam logic signed [DW-1:0] V_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] V_MIN = {1'b1, {(DW-1){1'b0}}};

    logic signed [PW-1:0] r1_sq_re, r1_sq_im;
    logic [DW-1:0]        r1_mag_re, r1_mag_im;
    logic                 r1_neg_re, r1_neg_im;

    logic [PW-1:0]        r2_den;
    logic [DW-1:0]        r2_mag_re, r2_mag_im;
    logic                 r2_neg_re, r2_neg_im;

    logic [NW-1:0]        r3_num_re, r3_num_im;
    logic [PW-1:0]        r3_den;
    logic                 r3_neg_re, r3_neg_im;

    logic [PW-1:0]        r_rem_re [0:QB];
    logic [PW-1:0]        r_rem_im [0:QB];
    logic [QB-1:0]        r_low_re [0:QB];
    logic [QB-1:0]        r_low_im [0:QB];
    logic [QB-1:0]        r_q_re   [0:QB];
    logic [QB-1:0]        r_q_im   [0:QB];
    logic [PW-1:0]        r_den    [0:QB];
    logic                 r_neg_re [0:QB];
    logic                 r_neg_im [0:QB];
    logic                 r_ov_re  [0:QB];
    logic                 r_ov_im  [0:QB];
    logic                 r_zero   [0:QB];

    logic [PW-1:0]        n_rem_re [0:QB-1];
    logic [PW-1:0]        n_rem_im [0:QB-1];
    logic [QB-1:0]        n_q_re   [0:QB-1];
    logic [QB-1:0]        n_q_im   [0:QB-1];

    logic signed [DW-1:0] r_out_re, r_out_im;
    t_rcp_flags           r_out_flags;

    logic [DW:0]          n_fin_re, n_fin_im;

    function automatic logic [DW:0] finish(input logic [QB-1:0] q, input logic ov,
                                           input logic neg);
        logic [DW:0] res;
        begin
            if (neg) begin
                if (ov || q > Q_LIM) res = {1'b1, V_MIN};
                else                 res = {1'b0, DW'(QB'(0) - q)};
            end else begin
                if (ov || q >= Q_LIM) res = {1'b1, V_MAX};
                else                  res = {1'b0, DW'(q)};
            end
            return res;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        r1_sq_re  <= PW'(i_re) * PW'(i_re);
        r1_sq_im  <= PW'(i_im) * PW'(i_im);
        r1_mag_re <= i_re[DW-1] ? DW'(-i_re) : DW'(i_re);
        r1_mag_im <= i_im[DW-1] ? DW'(-i_im) : DW'(i_im);
        r1_neg_re <= i_re[DW-1];
        r1_neg_im <= !i_im[DW-1] && (i_im != '0);

        r2_den    <= PW'(unsigned'(r1_sq_re)) + PW'(unsigned'(r1_sq_im));
        r2_mag_re <= r1_mag_re;
        r2_mag_im <= r1_mag_im;
        r2_neg_re <= r1_neg_re;
        r2_neg_im <= r1_neg_im;

        r3_num_re <= (NW'(r2_mag_re) << (2 * F)) + NW'(r2_den >> 1);
        r3_num_im <= (NW'(r2_mag_im) << (2 * F)) + NW'(r2_den >> 1);
        r3_den    <= r2_den;
        r3_neg_re <= r2_neg_re;
        r3_neg_im <= r2_neg_im;

        r_rem_re[0] <= PW'(r3_num_re >> QB);
        r_rem_im[0] <= PW'(r3_num_im >> QB);
        r_low_re[0] <= r3_num_re[QB-1:0];
        r_low_im[0] <= r3_num_im[QB-1:0];
        r_q_re[0]   <= '0;
        r_q_im[0]   <= '0;
        r_den[0]    <= r3_den;
        r_neg_re[0] <= r3_neg_re;
        r_neg_im[0] <= r3_neg_im;
        r_ov_re[0]  <= (r3_num_re >> QB) >= NW'(r3_den);
        r_ov_im[0]  <= (r3_num_im >> QB) >= NW'(r3_den);
        r_zero[0]   <= (r3_den == '0);

        for (int k = 0; k < QB; k++) begin
            r_rem_re[k+1] <= n_rem_re[k];
            r_rem_im[k+1] <= n_rem_im[k];
            r_low_re[k+1] <= r_low_re[k] << 1;
            r_low_im[k+1] <= r_low_im[k] << 1;
            r_q_re[k+1]   <= n_q_re[k];
            r_q_im[k+1]   <= n_q_im[k];
            r_den[k+1]    <= r_den[k];
            r_neg_re[k+1] <= r_neg_re[k];
            r_neg_im[k+1] <= r_neg_im[k];
            r_ov_re[k+1]  <= r_ov_re[k];
            r_ov_im[k+1]  <= r_ov_im[k];
            r_zero[k+1]   <= r_zero[k];
        end

        if (r_zero[QB]) begin
            r_out_re    <= '0;
            r_out_im    <= '0;
            r_out_flags <= '{ovf: 1'b0, zero: 1'b1};
        end else begin
            r_out_re    <= n_fin_re[DW-1:0];
            r_out_im    <= n_fin_im[DW-1:0];
            r_out_flags <= '{ovf: n_fin_re[DW] | n_fin_im[DW], zero: 1'b0};
        end
    end

    always_comb begin
        logic [PW:0] t_re;
        logic [PW:0] t_im;
        logic        ge_re;
        logic        ge_im;
        for (int k = 0; k < QB; k++) begin
            t_re = {r_rem_re[k], r_low_re[k][QB-1]};
            t_im = {r_rem_im[k], r_low_im[k][QB-1]};
            ge_re = t_re >= {1'b0, r_den[k]};
            ge_im = t_im >= {1'b0, r_den[k]};
            n_rem_re[k] = ge_re ? PW'(t_re - {1'b0, r_den[k]}) : PW'(t_re);
            n_rem_im[k] = ge_im ? PW'(t_im - {1'b0, r_den[k]}) : PW'(t_im);
            n_q_re[k] = {r_q_re[k][QB-2:0], ge_re};
            n_q_im[k] = {r_q_im[k][QB-2:0], ge_im};
        end
    end

    assign n_fin_re = finish(r_q_re[QB], r_ov_re[QB], r_neg_re[QB]);
    assign n_fin_im = finish(r_q_im[QB], r_ov_im[QB], r_neg_im[QB]);

    assign o_q_re  = r_out_re;
    assign o_q_im  = r_out_im;
    assign o_flags = r_out_flags;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the fixed-point complex arithmetic unit.
`timescale 1ns / 100ps

module tb_top;
    import cau_pkg::*;

    localparam int LATENCY = 42;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0] status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [3:0] i_command;
    logic signed [31:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic o_done;
    logic signed [31:0] o_result_re, o_result_im;
    logic [1:0] o_status;

    t_answer expected_answers[$];
    int mismatch_count;
    int idle_cycles;
    bit gaps_enabled;

    complex_arithmetic_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_a_re(i_a_re), .i_a_im(i_a_im),
        .i_b_re(i_b_re), .i_b_im(i_b_im), .o_done(o_done),
        .o_result_re(o_result_re), .o_result_im(o_result_im), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v, ref bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint rounded_quotient(longint unsigned mag, bit neg,
                                                longint unsigned den, ref bit ovf);
        longint unsigned q;
        q = ((mag << 32) + den / 2) / den;
        if (neg) begin
            if (q > 64'd2147483648) begin
                ovf = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(q);
    endfunction

    function automatic bit invert(longint re, longint im, ref longint rr, ref longint ri,
                                  ref bit ovf);
        longint unsigned den;
        den = longint'(re * re) + longint'(im * im);
        if (den == 0) return 1'b0;
        rr = rounded_quotient(re < 0 ? -re : re, re < 0, den, ovf);
        ri = rounded_quotient(im < 0 ? -im : im, im > 0, den, ovf);
        return 1'b1;
    endfunction

    function automatic void vector_rotate(longint re, longint im, ref longint x,
                                          ref longint z);
        longint y, xs, ys;
        x = re;
        y = im;
        z = 0;
        if (re < 0) begin
            x = -re;
            y = -im;
            z = (im >= 0) ? longint'(CAU_PI) : -longint'(CAU_PI);
        end
        for (int i = 0; i < 16; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += longint'(CAU_ATAN[i]);
            end else begin
                x -= ys;
                y += xs;
                z -= longint'(CAU_ATAN[i]);
            end
        end
    endfunction

    function automatic t_answer complex_result(logic [3:0] cmd, logic signed [31:0] a_re,
                                               logic signed [31:0] a_im,
                                               logic signed [31:0] b_re,
                                               logic signed [31:0] b_im);
        longint ar, ai, br, bi, rr, ri, t0, t1, x, z;
        bit ovf;
        t_answer ans;
        ar = a_re;
        ai = a_im;
        br = b_re;
        bi = b_im;
        rr = 0;
        ri = 0;
        t0 = 0;
        t1 = 0;
        ovf = 1'b0;
        ans.status = ST_OK;
        case (cmd)
            CMD_ADD: begin
                rr = clamp32(ar + br, ovf);
                ri = clamp32(ai + bi, ovf);
            end
            CMD_SUB: begin
                rr = clamp32(ar - br, ovf);
                ri = clamp32(ai - bi, ovf);
            end
            CMD_MUL: begin
                rr = clamp32(round_q(ar * br - ai * bi, 16), ovf);
                ri = clamp32(round_q(ar * bi + ai * br, 16), ovf);
            end
            CMD_DIV: begin
                if (!invert(br, bi, t0, t1, ovf)) begin
                    ans.status = ST_DIV0;
                end else begin
                    rr = clamp32(round_q(ar * t0 - ai * t1, 16), ovf);
                    ri = clamp32(round_q(ar * t1 + ai * t0, 16), ovf);
                end
            end
            CMD_CONJ: begin
                rr = ar;
                ri = clamp32(-ai, ovf);
            end
            CMD_RECIP: begin
                if (!invert(ar, ai, rr, ri, ovf)) begin
                    ans.status = ST_DIV0;
                    rr = 0;
                    ri = 0;
                end
            end
            CMD_SCALE: begin
                rr = clamp32(round_q(ar * br, 16), ovf);
                ri = clamp32(round_q(ai * br, 16), ovf);
            end
            CMD_MAG: begin
                if (ar != 0 || ai != 0) begin
                    vector_rotate(ar, ai, x, z);
                    rr = clamp32(round_q(x * longint'(CAU_GAIN), 30), ovf);
                end
            end
            CMD_ARG: begin
                if (ar != 0 || ai != 0) begin
                    vector_rotate(ar, ai, x, z);
                    rr = clamp32(round_q(z, 14), ovf);
                end
            end
            default: ;
        endcase
        if (ans.status == ST_OK && ovf) ans.status = ST_OVF;
        ans.re = rr[31:0];
        ans.im = ri[31:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (expected_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected word: re=%0d im=%0d st=%0d",
                                                   o_result_re, o_result_im, o_status);
            end else begin
                want = expected_answers.pop_front();
                if (o_result_re !== want.re || o_result_im !== want.im ||
                    o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                                 want.re, want.im, want.status,
                                 o_result_re, o_result_im, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_word(logic [3:0] cmd, logic signed [31:0] a_re,
                             logic signed [31:0] a_im, logic signed [31:0] b_re,
                             logic signed [31:0] b_im);
        int gap;
        if (gaps_enabled && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_a_re <= a_re;
        i_a_im <= a_im;
        i_b_re <= b_re;
        i_b_im <= b_im;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_answers.push_back(complex_result(cmd, a_re, a_im, b_re, b_im));
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: return $signed($urandom_range(0, 4)) - 2;
            2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
            3: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] big, low, one;
        big = 32'sh7fffffff;
        low = 32'sh80000000;
        one = 32'sh00010000;
        send_word(CMD_ADD, big, low, big, low);
        send_word(CMD_SUB, low, big, big, low);
        send_word(CMD_MUL, big, big, low, big);
        send_word(CMD_MUL, one, one, one, -one);
        send_word(CMD_DIV, one, one, 0, 0);
        send_word(CMD_DIV, big, low, 1, 0);
        send_word(CMD_DIV, one, 3 * one, 2 * one, -one);
        send_word(CMD_CONJ, big, low, 0, 0);
        send_word(CMD_CONJ, low, big, 0, 0);
        send_word(CMD_RECIP, 0, 0, 0, 0);
        send_word(CMD_RECIP, 1, 1, 0, 0);
        send_word(CMD_RECIP, low, low, 0, 0);
        send_word(CMD_SCALE, big, low, low, 0);
        send_word(CMD_MAG, 0, 0, 0, 0);
        send_word(CMD_MAG, big, big, 0, 0);
        send_word(CMD_MAG, low, low, 0, 0);
        send_word(CMD_ARG, 0, 0, 0, 0);
        send_word(CMD_ARG, -one, 0, 0, 0);
        send_word(CMD_ARG, -one, -1, 0, 0);
        send_word(CMD_ARG, 0, one, 0, 0);
        send_word(4'd9, one, one, one, one);
        send_word(4'd15, big, low, big, low);
    endtask

    task automatic test_random(int count);
        logic [3:0] cmd;
        for (int n = 0; n < count; n++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            send_word(cmd, pick_value(), pick_value(), pick_value(), pick_value());
        end
    endtask

    task automatic test_back_to_back(int count);
        gaps_enabled = 1'b0;
        test_random(count);
    endtask

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
        gaps_enabled = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = '0;
        i_a_re = '0;
        i_a_im = '0;
        i_b_re = '0;
        i_b_im = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1200);
        test_back_to_back(330);
        start <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
